// File: design/assert_macros.svh
// Assertion macros shared by the operand address unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is asserted.
`define COAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check with the consequent in the cycle after the antecedent.
`define COAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/coau_pkg.sv
// Package with types and codes for the operand address unit.
`default_nettype none

package coau_pkg;

  typedef logic [15:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  mode_t;
  typedef logic [1:0]  status_t;
  typedef logic [2:0]  phase_t;

  // Addressing modes.
  localparam mode_t MODE_ACC  = 4'd0;
  localparam mode_t MODE_ABS  = 4'd1;
  localparam mode_t MODE_ABSX = 4'd2;
  localparam mode_t MODE_ABSY = 4'd3;
  localparam mode_t MODE_ZP   = 4'd4;
  localparam mode_t MODE_ZPX  = 4'd5;
  localparam mode_t MODE_ZPY  = 4'd6;
  localparam mode_t MODE_IMM  = 4'd7;
  localparam mode_t MODE_INDX = 4'd8;
  localparam mode_t MODE_INDY = 4'd9;
  localparam mode_t MODE_IND  = 4'd10;

  // Result status codes.
  localparam status_t ST_REQ  = 2'd0;
  localparam status_t ST_DONE = 2'd1;
  localparam status_t ST_ERR  = 2'd2;

  // Input item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // Decode phases.
  localparam phase_t PH_IDLE   = 3'd0;
  localparam phase_t PH_OP_LO  = 3'd1;
  localparam phase_t PH_OP_HI  = 3'd2;
  localparam phase_t PH_PTR_LO = 3'd3;
  localparam phase_t PH_PTR_HI = 3'd4;

  localparam addr_t PAGE_MASK = 16'hFF00;

  typedef struct packed {
    status_t status;
    addr_t   address;
    addr_t   new_pc;
  } result_t;

endpackage

`default_nettype wire

// File: design/cpu_operand_address_unit.sv
// Operand address unit: effective address sequencing for 6502-style addressing modes.
// An input transfer passes through the input register, then the result register, to its result.
// Throughput: one item per cycle when the output is not stalled; the result register and the
// input register both advance whenever the output side is not stalled.
// Reset (synchronous, active low) empties both registers and returns the decode to idle.
`default_nettype none

module cpu_operand_address_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  coau_pkg::mode_t     in_mode,
  input  coau_pkg::addr_t     in_pc,
  input  coau_pkg::byte_t     in_x_index,
  input  coau_pkg::byte_t     in_y_index,
  input  coau_pkg::byte_t     in_read_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output coau_pkg::status_t   out_status,
  output coau_pkg::addr_t     out_address,
  output coau_pkg::addr_t     out_new_pc
);
  import coau_pkg::*;

  `include "assert_macros.svh"

  // Input register.
  logic    s1_valid_r;
  logic    s1_kind_r;
  mode_t   s1_mode_r;
  addr_t   s1_pc_r;
  byte_t   s1_x_r;
  byte_t   s1_y_r;
  byte_t   s1_byte_r;

  // Decode state.
  phase_t  phase_r, phase_nxt;
  mode_t   held_mode_r, held_mode_nxt;
  addr_t   held_pc_r, held_pc_nxt;
  byte_t   held_x_r, held_x_nxt;
  byte_t   held_y_r, held_y_nxt;
  byte_t   low_byte_r, low_byte_nxt;
  addr_t   pointer_address_r, pointer_address_nxt;

  // Result register.
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic    advance;
  logic    in_xfer;
  logic    work;
  addr_t   word;
  addr_t   pc_plus1;
  addr_t   pc_plus2;
  byte_t   zp_x_sum;
  byte_t   zp_y_sum;
  byte_t   ptr_lo_inc;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign work     = s1_valid_r && advance;

  assign word       = {s1_byte_r, low_byte_r};
  assign pc_plus1   = held_pc_r + 16'd1;
  assign pc_plus2   = held_pc_r + 16'd2;
  assign zp_x_sum   = s1_byte_r + held_x_r;
  assign zp_y_sum   = s1_byte_r + held_y_r;
  assign ptr_lo_inc = pointer_address_r[7:0] + 8'd1;

  always_comb begin
    phase_nxt           = phase_r;
    held_mode_nxt       = held_mode_r;
    held_pc_nxt         = held_pc_r;
    held_x_nxt          = held_x_r;
    held_y_nxt          = held_y_r;
    low_byte_nxt        = low_byte_r;
    pointer_address_nxt = pointer_address_r;
    res_nxt.status      = ST_ERR;
    res_nxt.address     = '0;
    res_nxt.new_pc      = '0;

    if (s1_kind_r == KIND_START) begin
      held_mode_nxt = s1_mode_r;
      held_pc_nxt   = s1_pc_r;
      held_x_nxt    = s1_x_r;
      held_y_nxt    = s1_y_r;
      if (s1_mode_r == MODE_ACC || s1_mode_r > MODE_IND) begin
        phase_nxt = PH_IDLE;
      end else if (s1_mode_r == MODE_IMM) begin
        phase_nxt       = PH_IDLE;
        res_nxt.status  = ST_DONE;
        res_nxt.address = s1_pc_r;
        res_nxt.new_pc  = s1_pc_r + 16'd1;
      end else begin
        phase_nxt       = PH_OP_LO;
        res_nxt.status  = ST_REQ;
        res_nxt.address = s1_pc_r;
      end
    end else begin
      phase_nxt = PH_IDLE;
      case (phase_r)
        PH_OP_LO: begin
          case (held_mode_r)
            MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
              low_byte_nxt    = s1_byte_r;
              phase_nxt       = PH_OP_HI;
              res_nxt.status  = ST_REQ;
              res_nxt.address = pc_plus1;
            end
            MODE_ZP: begin
              res_nxt.status  = ST_DONE;
              res_nxt.address = {8'h00, s1_byte_r};
              res_nxt.new_pc  = pc_plus1;
            end
            MODE_ZPX: begin
              res_nxt.status  = ST_DONE;
              res_nxt.address = {8'h00, zp_x_sum};
              res_nxt.new_pc  = pc_plus1;
            end
            MODE_ZPY: begin
              res_nxt.status  = ST_DONE;
              res_nxt.address = {8'h00, zp_y_sum};
              res_nxt.new_pc  = pc_plus1;
            end
            MODE_INDX: begin
              pointer_address_nxt = {8'h00, zp_x_sum};
              phase_nxt           = PH_PTR_LO;
              res_nxt.status      = ST_REQ;
              res_nxt.address     = {8'h00, zp_x_sum};
            end
            MODE_INDY: begin
              pointer_address_nxt = {8'h00, s1_byte_r};
              phase_nxt           = PH_PTR_LO;
              res_nxt.status      = ST_REQ;
              res_nxt.address     = {8'h00, s1_byte_r};
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        PH_OP_HI: begin
          case (held_mode_r)
            MODE_ABS: begin
              res_nxt.status  = ST_DONE;
              res_nxt.address = word;
              res_nxt.new_pc  = pc_plus2;
            end
            MODE_ABSX: begin
              res_nxt.status  = ST_DONE;
              res_nxt.address = word + {8'h00, held_x_r};
              res_nxt.new_pc  = pc_plus2;
            end
            MODE_ABSY: begin
              res_nxt.status  = ST_DONE;
              res_nxt.address = word + {8'h00, held_y_r};
              res_nxt.new_pc  = pc_plus2;
            end
            MODE_IND: begin
              pointer_address_nxt = word;
              phase_nxt           = PH_PTR_LO;
              res_nxt.status      = ST_REQ;
              res_nxt.address     = word;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        PH_PTR_LO: begin
          low_byte_nxt   = s1_byte_r;
          phase_nxt      = PH_PTR_HI;
          res_nxt.status = ST_REQ;
          // The indirect jump never carries into the pointer's high byte.
          if (held_mode_r == MODE_IND) begin
            res_nxt.address = (pointer_address_r & PAGE_MASK) | {8'h00, ptr_lo_inc};
          end else begin
            res_nxt.address = {8'h00, ptr_lo_inc};
          end
        end
        PH_PTR_HI: begin
          res_nxt.status = ST_DONE;
          if (held_mode_r == MODE_IND) begin
            res_nxt.address = word;
            res_nxt.new_pc  = pc_plus2;
          end else if (held_mode_r == MODE_INDY) begin
            res_nxt.address = word + {8'h00, held_y_r};
            res_nxt.new_pc  = pc_plus1;
          end else begin
            res_nxt.address = word;
            res_nxt.new_pc  = pc_plus1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
    end else begin
      if (advance) begin
        s1_valid_r  <= in_xfer;
        out_valid_r <= s1_valid_r;
      end else if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end
      if (work) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= in_kind;
      s1_mode_r <= in_mode;
      s1_pc_r   <= in_pc;
      s1_x_r    <= in_x_index;
      s1_y_r    <= in_y_index;
      s1_byte_r <= in_read_byte;
    end
    if (work) begin
      held_mode_r       <= held_mode_nxt;
      held_pc_r         <= held_pc_nxt;
      held_x_r          <= held_x_nxt;
      held_y_r          <= held_y_nxt;
      low_byte_r        <= low_byte_nxt;
      pointer_address_r <= pointer_address_nxt;
      res_r             <= res_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = res_r.status;
  assign out_address = res_r.address;
  assign out_new_pc  = res_r.new_pc;

  `COAU_ASSERT(a_phase_legal, (phase_r <= PH_PTR_HI), "decode phase out of range")
  `COAU_ASSERT(a_err_zero, (out_valid_r && res_r.status == ST_ERR) |-> (res_r.address == '0 && res_r.new_pc == '0), "error result carries nonzero fields")
  `COAU_ASSERT(a_req_pc_zero, (out_valid_r && res_r.status == ST_REQ) |-> (res_r.new_pc == '0), "read request carries a program counter")
  `COAU_ASSERT_NEXT(a_xfer_held, (in_valid && !in_stall), s1_valid_r, "input transfer not captured")
  `COAU_ASSERT_NEXT(a_work_out, (s1_valid_r && advance), out_valid_r, "processed item produced no result")

endmodule

`default_nettype wire
